// ===== sv/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
package mcr_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned RadW = 7;
  localparam int unsigned ColorW = 15;
  localparam int unsigned IndexW = 16;
  localparam int unsigned NumPts = 8;
  localparam int unsigned PosW = 11;
  localparam int unsigned OctW = 8;
  localparam int unsigned DecW = 12;
  localparam int unsigned StepLimit = 60;
  localparam int unsigned CntW = $clog2(StepLimit);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP
  } mcr_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic emit;
  } mcr_cmd_t;

  typedef struct packed {
    logic last;
  } mcr_sts_t;

endpackage

// ===== sv/midpoint_circle_rasterizer_core.sv =====
// Top level of the midpoint circle rasterizer: controller, datapath and ports.
// One request (centre, radius, colour) produces one result per step of the
// midpoint circle recurrence: about r/sqrt(2) + 2 results for radius r, at
// most 60. After acceptance the block forms the row bases (a multiply by the
// screen width) in its setup state, then emits one result per cycle into its
// output register while the receiver does not stall. The next request is
// accepted once the final result has entered the output register, even if it
// still waits.
module midpoint_circle_rasterizer_core
  import mcr_pkg::*;
#(
  parameter int unsigned SCREEN_W   = 240,
  parameter int unsigned SCREEN_H   = 160,
  parameter int unsigned MAX_RADIUS = 80
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] center_x,
  input  logic signed [CoordW-1:0] center_y,
  input  logic        [RadW-1:0]   radius,
  input  logic        [ColorW-1:0] pen_color,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [IndexW-1:0] index_px_py,
  output logic        [IndexW-1:0] index_nx_py,
  output logic        [IndexW-1:0] index_px_ny,
  output logic        [IndexW-1:0] index_nx_ny,
  output logic        [IndexW-1:0] index_py_px,
  output logic        [IndexW-1:0] index_ny_px,
  output logic        [IndexW-1:0] index_py_nx,
  output logic        [IndexW-1:0] index_ny_nx,
  output logic        [NumPts-1:0] on_screen_mask,
  output logic        [ColorW-1:0] pixel_color,
  output logic                     last_of_circle
);

  mcr_cmd_t          cmd;
  mcr_sts_t          sts;
  logic [IndexW-1:0] index [NumPts];

  mcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mcr_datapath #(
    .SCREEN_W   (SCREEN_W),
    .SCREEN_H   (SCREEN_H),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .center_x       (center_x),
    .center_y       (center_y),
    .radius         (radius),
    .pen_color      (pen_color),
    .index          (index),
    .on_screen_mask (on_screen_mask),
    .pixel_color    (pixel_color),
    .last_of_circle (last_of_circle)
  );

  assign index_px_py = index[0];
  assign index_nx_py = index[1];
  assign index_px_ny = index[2];
  assign index_nx_ny = index[3];
  assign index_py_px = index[4];
  assign index_ny_px = index[5];
  assign index_py_nx = index[6];
  assign index_ny_nx = index[7];

endmodule

// ===== sv/mcr_ctrl.sv =====
// Controller state machine for the midpoint circle rasterizer.
module mcr_ctrl
  import mcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output mcr_cmd_t cmd,
  input  mcr_sts_t sts
);

  mcr_state_t state;
  mcr_state_t state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (!out_valid || !out_stall) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("Result loaded while the output register still held an item.");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.last) |=> (state == ST_IDLE))
    else $error("Controller did not return to idle after the final result.");

  a_init_step: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> ##1 (state == ST_STEP))
    else $error("Setup did not lead into stepping.");

endmodule

// ===== sv/mcr_datapath.sv =====
// Datapath: midpoint recurrence, incremental row bases and output register.
module mcr_datapath
  import mcr_pkg::*;
#(
  parameter int unsigned SCREEN_W   = 240,
  parameter int unsigned SCREEN_H   = 160,
  parameter int unsigned MAX_RADIUS = 80
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mcr_cmd_t                  cmd,
  output mcr_sts_t                  sts,
  input  logic signed [CoordW-1:0]  center_x,
  input  logic signed [CoordW-1:0]  center_y,
  input  logic        [RadW-1:0]    radius,
  input  logic        [ColorW-1:0]  pen_color,
  output logic        [IndexW-1:0]  index [NumPts],
  output logic        [NumPts-1:0]  on_screen_mask,
  output logic        [ColorW-1:0]  pixel_color,
  output logic                      last_of_circle
);

  localparam int unsigned BaseW = PosW + $clog2(SCREEN_W) + 1;
  localparam logic signed [BaseW-1:0] WStep = BaseW'(SCREEN_W);
  localparam logic [PosW:0] WLim = (PosW + 1)'(SCREEN_W);
  localparam logic [PosW:0] HLim = (PosW + 1)'(SCREEN_H);
  localparam logic [RadW-1:0] RadMax = RadW'(MAX_RADIUS);

  logic signed [OctW-1:0]  x;
  logic signed [OctW-1:0]  y;
  logic signed [DecW-1:0]  d;
  logic        [CntW-1:0]  cnt;
  logic        [ColorW-1:0] color;
  logic signed [PosW-1:0]  cpx, cnx, cpy, cny;
  logic signed [PosW-1:0]  rpy, rny, rpx, rnx;
  logic signed [BaseW-1:0] bpy, bny, bpx, bnx;

  logic        [RadW-1:0]  r_sat;
  logic signed [PosW-1:0]  r_ext;
  logic signed [PosW-1:0]  col_pt  [NumPts];
  logic signed [PosW-1:0]  row_pt  [NumPts];
  logic signed [BaseW-1:0] base_pt [NumPts];
  logic        [IndexW-1:0] index_next [NumPts];
  logic        [NumPts-1:0] mask_next;
  logic signed [BaseW-1:0] sum_pt  [NumPts];
  logic signed [OctW:0]    diff;
  logic signed [DecW-1:0]  d_next;
  logic                    step_y;

  assign r_sat = (radius > RadMax) ? RadMax : radius;
  assign r_ext = $signed({{(PosW - RadW){1'b0}}, r_sat});

  assign sts.last = (y < x) || (cnt == CntW'(StepLimit - 1));

  assign step_y = (d > 0);
  assign diff   = (OctW + 1)'(x) - (OctW + 1)'(y) + (OctW + 1)'(1);

  always_comb begin
    if (step_y) begin
      d_next = d + (DecW'(diff) <<< 2) + DecW'(10);
    end else begin
      d_next = d + (DecW'(x) <<< 2) + DecW'(6);
    end
  end

  always_comb begin
    col_pt[0] = cpx; row_pt[0] = rpy; base_pt[0] = bpy;
    col_pt[1] = cnx; row_pt[1] = rpy; base_pt[1] = bpy;
    col_pt[2] = cpx; row_pt[2] = rny; base_pt[2] = bny;
    col_pt[3] = cnx; row_pt[3] = rny; base_pt[3] = bny;
    col_pt[4] = cpy; row_pt[4] = rpx; base_pt[4] = bpx;
    col_pt[5] = cny; row_pt[5] = rpx; base_pt[5] = bpx;
    col_pt[6] = cpy; row_pt[6] = rnx; base_pt[6] = bnx;
    col_pt[7] = cny; row_pt[7] = rnx; base_pt[7] = bnx;
    for (int i = 0; i < NumPts; i++) begin
      sum_pt[i] = base_pt[i] + BaseW'(col_pt[i]);
      mask_next[i] = !col_pt[i][PosW-1] && !row_pt[i][PosW-1]
                     && ((PosW + 1)'(col_pt[i][PosW-2:0]) < WLim)
                     && ((PosW + 1)'(row_pt[i][PosW-2:0]) < HLim);
      index_next[i] = mask_next[i] ? sum_pt[i][IndexW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.emit) begin
      cnt <= cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= '0;
      y     <= $signed({{(OctW - RadW){1'b0}}, r_sat});
      d     <= DecW'(3) - (DecW'(r_sat) <<< 1);
      color <= pen_color;
      cpx   <= PosW'(center_x);
      cnx   <= PosW'(center_x);
      cpy   <= PosW'(center_x) + r_ext;
      cny   <= PosW'(center_x) - r_ext;
      rpx   <= PosW'(center_y);
      rnx   <= PosW'(center_y);
      rpy   <= PosW'(center_y) + r_ext;
      rny   <= PosW'(center_y) - r_ext;
    end else if (cmd.init) begin
      bpy <= BaseW'(rpy) * WStep;
      bny <= BaseW'(rny) * WStep;
      bpx <= BaseW'(rpx) * WStep;
      bnx <= BaseW'(rpx) * WStep;
    end else if (cmd.emit) begin
      x   <= x + OctW'(1);
      d   <= d_next;
      cpx <= cpx + PosW'(1);
      cnx <= cnx - PosW'(1);
      rpx <= rpx + PosW'(1);
      rnx <= rnx - PosW'(1);
      bpx <= bpx + WStep;
      bnx <= bnx - WStep;
      if (step_y) begin
        y   <= y - OctW'(1);
        cpy <= cpy - PosW'(1);
        cny <= cny + PosW'(1);
        rpy <= rpy - PosW'(1);
        rny <= rny + PosW'(1);
        bpy <= bpy - WStep;
        bny <= bny + WStep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      index          <= index_next;
      on_screen_mask <= mask_next;
      pixel_color    <= color;
      last_of_circle <= sts.last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(StepLimit - 1))
    else $error("Step count ran past the step limit.");

  a_last_at_limit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cnt == CntW'(StepLimit - 1)) |=> last_of_circle)
    else $error("Result at the step limit was not marked as final.");

  a_x_steps: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !cmd.load) |=> (x == $past(x) + OctW'(1)))
    else $error("Column offset did not advance on a step.");

endmodule
